FILE: rtl/keyed_counter_least_select_top_defines.svh
// ---------------------------------------------------------------------------
// keyed_counter_least_select_top_defines
// Assertion macros shared by the keyed counter table.
// ---------------------------------------------------------------------------
`ifndef KEYED_COUNTER_LEAST_SELECT_TOP_DEFINES_SVH
`define KEYED_COUNTER_LEAST_SELECT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KCLS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KCLS_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/kcls_pkg.sv
// ---------------------------------------------------------------------------
// kcls_pkg
// Shared types and constants of the keyed counter table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcls_pkg;

  localparam int KEY_W   = 48;
  localparam int TOTAL_W = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    FN_COUNT  = 2'd0,
    FN_TOUCH  = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  // control word that travels along the cell row
  typedef struct packed {
    logic act;   // wave present at this cell
    logic ph2;   // 0: key search pass, 1: update and reduce pass
    logic hit;   // key found in the table
    logic ins;   // insert still waiting for a free slot
    logic fnd;   // at least one valid entry seen so far
  } wave_t;

endpackage

`default_nettype wire

FILE: rtl/kcls_cell.sv
// ---------------------------------------------------------------------------
// kcls_cell
// One table entry: holds key, tally and valid bit, applies the command when
// the update wave passes, and folds itself into the running minimum and sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcls_cell #(
  parameter int TALLY_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  kcls_pkg::func_t                  cmd_func,
  input  wire [kcls_pkg::KEY_W-1:0]        cmd_key,
  input  kcls_pkg::wave_t                  wave_in,
  input  wire [kcls_pkg::KEY_W-1:0]        lkey_in,
  input  wire [TALLY_WIDTH-1:0]            ltally_in,
  input  wire [kcls_pkg::TOTAL_W-1:0]      total_in,
  output kcls_pkg::wave_t                  wave_out,
  output logic [kcls_pkg::KEY_W-1:0]       lkey_out,
  output logic [TALLY_WIDTH-1:0]           ltally_out,
  output logic [kcls_pkg::TOTAL_W-1:0]     total_out
);
  import kcls_pkg::*;

  localparam int SUM_W = ((TALLY_WIDTH > TOTAL_W) ? TALLY_WIDTH : TOTAL_W) + 1;
  localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;
  localparam logic [TALLY_WIDTH-1:0] TALLY_ONE = TALLY_WIDTH'(1);

  logic                   valid_r, valid_nxt;
  logic [TALLY_WIDTH-1:0] tally_r, tally_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  wave_t                  wave_r, wave_nxt;
  logic [KEY_W-1:0]       lkey_r, lkey_nxt;
  logic [TALLY_WIDTH-1:0] ltally_r, ltally_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;

  logic             match;
  logic             upd;
  logic             ins_nxt;
  logic             take;
  logic [SUM_W-1:0] sum;

  assign match = valid_r && (key_r == cmd_key);
  assign upd   = wave_in.act && wave_in.ph2;

  always_comb begin
    valid_nxt = valid_r;
    tally_nxt = tally_r;
    key_nxt   = key_r;
    ins_nxt   = wave_in.ins;
    if (upd) begin
      case (cmd_func)
        FN_COUNT, FN_TOUCH: begin
          if (match) begin
            if ((cmd_func == FN_COUNT) && (tally_r != TALLY_MAX)) begin
              tally_nxt = tally_r + TALLY_ONE;
            end
          end else if (wave_in.ins && !valid_r) begin
            valid_nxt = 1'b1;
            key_nxt   = cmd_key;
            tally_nxt = (cmd_func == FN_COUNT) ? TALLY_ONE : '0;
            ins_nxt   = 1'b0;
          end
        end
        FN_REMOVE: begin
          if (match) begin
            valid_nxt = 1'b0;
            tally_nxt = '0;
          end
        end
        FN_CLEAR: begin
          valid_nxt = 1'b0;
          tally_nxt = '0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // fold this entry into the running minimum and saturating sum
  assign sum  = SUM_W'(total_in) + SUM_W'(tally_nxt);
  assign take = valid_nxt && (!wave_in.fnd || (tally_nxt < ltally_in) ||
                ((tally_nxt == ltally_in) && (key_nxt < lkey_in)));

  always_comb begin
    wave_nxt     = wave_in;
    lkey_nxt     = lkey_in;
    ltally_nxt   = ltally_in;
    total_nxt    = total_in;
    wave_nxt.ins = ins_nxt;
    if (wave_in.act && !wave_in.ph2) begin
      wave_nxt.hit = wave_in.hit | match;
    end
    if (upd && valid_nxt) begin
      wave_nxt.fnd = 1'b1;
      total_nxt    = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (take) begin
        lkey_nxt   = key_nxt;
        ltally_nxt = tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tally_r <= '0;
      wave_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      tally_r <= tally_nxt;
      wave_r  <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    lkey_r   <= lkey_nxt;
    ltally_r <= ltally_nxt;
    total_r  <= total_nxt;
  end

  assign wave_out   = wave_r;
  assign lkey_out   = lkey_r;
  assign ltally_out = ltally_r;
  assign total_out  = total_r;

endmodule

`default_nettype wire

FILE: rtl/keyed_counter_least_select_top.sv
// ---------------------------------------------------------------------------
// keyed_counter_least_select_top
// Table of server addresses with saturating counts, built as a row of cells.
// A new item is taken only once the last one is through: two waves pass over the
// cell row, one cell per cycle (key search, then update with min/sum fold).
// Reset: synchronous, clears all valid bits and counts; table empty.
// The receiver cannot stall; each result shows for one cycle on out_strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_counter_least_select_top_defines.svh"

module keyed_counter_least_select_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int TALLY_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [1:0]                        in_func,
  input  wire [kcls_pkg::KEY_W-1:0]        in_key_addr,
  output logic                             out_strobe,
  output logic [kcls_pkg::KEY_W-1:0]       out_least_addr,
  output logic                             out_least_found,
  output logic [kcls_pkg::TOTAL_W-1:0]     out_total_count,
  output logic                             out_dropped_full
);
  import kcls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  func_t              cmd_func_r;
  logic [KEY_W-1:0]   cmd_key_r;
  wave_t              inj_r, inj_nxt;
  logic               strobe_r, strobe_nxt;
  logic [KEY_W-1:0]   least_addr_r;
  logic               least_found_r;
  logic [TOTAL_W-1:0] total_r;
  logic               dropped_r;

  wave_t                  wave   [TABLE_DEPTH+1];
  logic [KEY_W-1:0]       lkey   [TABLE_DEPTH+1];
  logic [TALLY_WIDTH-1:0] ltally [TABLE_DEPTH+1];
  logic [TOTAL_W-1:0]     total  [TABLE_DEPTH+1];

  logic accept;
  logic is_ins;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign is_ins = (cmd_func_r == FN_COUNT) || (cmd_func_r == FN_TOUCH);

  assign wave[0]   = inj_r;
  assign lkey[0]   = '0;
  assign ltally[0] = '0;
  assign total[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kcls_cell #(
      .TALLY_WIDTH (TALLY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_func   (cmd_func_r),
      .cmd_key    (cmd_key_r),
      .wave_in    (wave[i]),
      .lkey_in    (lkey[i]),
      .ltally_in  (ltally[i]),
      .total_in   (total[i]),
      .wave_out   (wave[i+1]),
      .lkey_out   (lkey[i+1]),
      .ltally_out (ltally[i+1]),
      .total_out  (total[i+1])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    inj_nxt    = '0;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          inj_nxt.act = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wave[TABLE_DEPTH].act) begin
          inj_nxt.act = 1'b1;
          inj_nxt.ph2 = 1'b1;
          inj_nxt.hit = wave[TABLE_DEPTH].hit;
          inj_nxt.ins = is_ins && !wave[TABLE_DEPTH].hit;
          state_nxt   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (wave[TABLE_DEPTH].act) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      inj_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inj_r    <= inj_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func_r <= func_t'(in_func);
      cmd_key_r  <= in_key_addr;
    end
    if (strobe_nxt) begin
      least_addr_r  <= wave[TABLE_DEPTH].fnd ? lkey[TABLE_DEPTH] : '0;
      least_found_r <= wave[TABLE_DEPTH].fnd;
      total_r       <= total[TABLE_DEPTH];
      dropped_r     <= wave[TABLE_DEPTH].ins;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_least_addr   = least_addr_r;
  assign out_least_found  = least_found_r;
  assign out_total_count  = total_r;
  assign out_dropped_full = dropped_r;

  `KCLS_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result outside idle")
  `KCLS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
  `KCLS_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held")
  `KCLS_ASSERT_IMP(a_empty_zero, out_strobe && !out_least_found, out_least_addr == '0, "empty table with nonzero address")
  `KCLS_ASSERT_IMP(a_drop_full, out_strobe && out_dropped_full, out_least_found, "drop with empty table")

endmodule

`default_nettype wire

FILE: bench/kcls_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcls_table_checker
// Watches the item and result channels of the keyed counter table. It keeps
// a shadow table of addresses and saturating counts, derives the least-counted
// address, the non-empty flag, the count sum and the dropped-insert flag for
// every accepted item, and compares each strobed result with the oldest
// pending selection.
// ----------------------------------------------------------------------------
module kcls_table_checker #(
  parameter int TABLE_DEPTH = 16,
  parameter int TALLY_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire [1:0]                    in_func,
  input  wire [kcls_pkg::KEY_W-1:0]    in_key_addr,
  input  wire                          out_strobe,
  input  wire [kcls_pkg::KEY_W-1:0]    out_least_addr,
  input  wire                          out_least_found,
  input  wire [kcls_pkg::TOTAL_W-1:0]  out_total_count,
  input  wire                          out_dropped_full,
  output int                           err_count,
  output int                           pending
);
  import kcls_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]   least_addr;
    logic               least_found;
    logic [TOTAL_W-1:0] total_count;
    logic               dropped_full;
  } selection_t;

  localparam logic [TALLY_WIDTH-1:0] TALLY_TOP = '1;

  logic [KEY_W-1:0]       shadow_key   [TABLE_DEPTH];
  logic [TALLY_WIDTH-1:0] shadow_tally [TABLE_DEPTH];
  logic                   shadow_valid [TABLE_DEPTH];
  selection_t             selection_fifo [$];
  selection_t             got;
  selection_t             want;
  int                     idx;

  function automatic selection_t next_selection(func_t fn, logic [KEY_W-1:0] key);
    selection_t             sel;
    int                     slot;
    int                     i;
    logic [TALLY_WIDTH-1:0] least_tally;
    longint                 sum;
    sel = '0;
    slot = -1;
    sum = 0;
    least_tally = '0;
    for (i = 0; i < TABLE_DEPTH; i++)
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    case (fn)
      FN_COUNT, FN_TOUCH: begin
        if (slot < 0) begin
          for (i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && !shadow_valid[i]) begin
              slot = i;
              shadow_valid[i] = 1'b1;
              shadow_key[i] = key;
              shadow_tally[i] = '0;
            end
          end
        end
        if (slot < 0) begin
          sel.dropped_full = 1'b1;
        end else if (fn == FN_COUNT && shadow_tally[slot] != TALLY_TOP) begin
          shadow_tally[slot] += 1'b1;
        end
      end
      FN_REMOVE: begin
        if (slot >= 0) begin
          shadow_valid[slot] = 1'b0;
          shadow_tally[slot] = '0;
        end
      end
      FN_CLEAR: begin
        for (i = 0; i < TABLE_DEPTH; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_tally[i] = '0;
        end
      end
      default: begin
      end
    endcase
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_valid[i]) begin
        sum += shadow_tally[i];
        if (!sel.least_found || shadow_tally[i] < least_tally ||
            (shadow_tally[i] == least_tally && shadow_key[i] < sel.least_addr)) begin
          sel.least_found = 1'b1;
          least_tally = shadow_tally[i];
          sel.least_addr = shadow_key[i];
        end
      end
    end
    sel.total_count = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    return sel;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (idx = 0; idx < TABLE_DEPTH; idx++) begin
        shadow_valid[idx] = 1'b0;
        shadow_tally[idx] = '0;
        shadow_key[idx] = '0;
      end
      selection_fifo.delete();
      err_count <= 0;
      pending <= 0;
    end else begin
      if (out_strobe) begin
        got = {out_least_addr, out_least_found, out_total_count, out_dropped_full};
        if (selection_fifo.size() == 0) begin
          $display("%0t unexpected result: expected none, got addr %h found %b %s",
                   $time, got.least_addr, got.least_found,
                   $sformatf("total %0d dropped %b", got.total_count, got.dropped_full));
          err_count <= err_count + 1;
        end else begin
          want = selection_fifo.pop_front();
          if (got !== want) begin
            $display("%0t result mismatch: expected addr %h found %b total %0d dropped %b",
                     $time, want.least_addr, want.least_found, want.total_count,
                     want.dropped_full);
            $display("%0t                  actual   addr %h found %b total %0d dropped %b",
                     $time, got.least_addr, got.least_found, got.total_count,
                     got.dropped_full);
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) begin
        selection_fifo.push_back(next_selection(func_t'(in_func), in_key_addr));
      end
      pending <= selection_fifo.size();
    end
  end

endmodule

FILE: bench/keyed_counter_least_select_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_counter_least_select_top_test
// Drives the keyed counter table with a directed fill-and-drop sequence and
// then with bursts of operations on a small address pool, under three sender
// pacing modes. A narrow tally width lets counts reach saturation. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module keyed_counter_least_select_top_test;
  import kcls_pkg::*;

  localparam int DEPTH   = 16;
  localparam int TALLY_W = 4;
  localparam int POOL_N  = 20;
  localparam int SETTLE  = 2 * DEPTH + 4;
  localparam int LIMIT   = 500_000;

  localparam logic [KEY_W-1:0] FRESH_A = 48'h1234_5678_9ABC;
  localparam logic [KEY_W-1:0] FRESH_B = 48'h5555_AAAA_0050;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         in_func = FN_COUNT;
  logic [KEY_W-1:0]   in_key_addr = '0;
  logic               busy;
  logic               out_strobe;
  logic [KEY_W-1:0]   out_least_addr;
  logic               out_least_found;
  logic [TOTAL_W-1:0] out_total_count;
  logic               out_dropped_full;
  int                 err_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 op_tally [4];
  logic [KEY_W-1:0]   key_pool [POOL_N];

  keyed_counter_least_select_top #(
    .TABLE_DEPTH(DEPTH),
    .TALLY_WIDTH(TALLY_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key_addr     (in_key_addr),
    .out_strobe      (out_strobe),
    .out_least_addr  (out_least_addr),
    .out_least_found (out_least_found),
    .out_total_count (out_total_count),
    .out_dropped_full(out_dropped_full)
  );

  kcls_table_checker #(
    .TABLE_DEPTH(DEPTH),
    .TALLY_WIDTH(TALLY_W)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key_addr     (in_key_addr),
    .out_strobe      (out_strobe),
    .out_least_addr  (out_least_addr),
    .out_least_found (out_least_found),
    .out_total_count (out_total_count),
    .out_dropped_full(out_dropped_full),
    .err_count       (err_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k[47:16] = $urandom;
    k[15:0] = 16'($urandom_range(0, 16'hFFFF));
    return k;
  endfunction

  task automatic send_item(func_t fn, logic [KEY_W-1:0] key, int idle_pct);
    logic offered;
    logic done;
    in_func <= fn;
    in_key_addr <= key;
    done = 1'b0;
    while (!done) begin
      offered = ($urandom_range(0, 99) >= idle_pct);
      start <= offered;
      @(posedge clk);
      done = offered && !busy;
    end
    op_tally[fn]++;
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int idle_pct);
    int               sent;
    int               burst;
    int               r;
    func_t            fn;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        send_item(func_t'($urandom_range(0, 3)), rand_key(), idle_pct);
        sent++;
      end else begin
        key = key_pool[$urandom_range(0, POOL_N - 1)];
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < 60) fn = FN_COUNT;
          else if (r < 80) fn = FN_TOUCH;
          else if (r < 98) fn = FN_REMOVE;
          else fn = FN_CLEAR;
          send_item(fn, key, idle_pct);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    int i;
    for (i = 0; i < 4; i++) op_tally[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_N; i++) key_pool[i] = rand_key();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FN_COUNT, '0, 0);
    send_item(FN_COUNT, '1, 0);
    send_item(FN_COUNT, '1, 0);
    send_item(FN_TOUCH, '1, 0);
    send_item(FN_TOUCH, FRESH_A, 0);
    send_item(FN_REMOVE, FRESH_B, 0);
    send_item(FN_REMOVE, '0, 0);
    for (i = 0; i < DEPTH - 2; i++)
      send_item(FN_TOUCH, {32'h0A00_0000 + 32'(DEPTH - i), 16'h1F90}, 0);
    send_item(FN_COUNT, FRESH_B, 0);
    send_item(FN_TOUCH, FRESH_B, 0);
    send_item(FN_REMOVE, FRESH_A, 0);
    send_item(FN_COUNT, FRESH_B, 0);
    send_item(FN_CLEAR, '0, 0);
    drain();

    run_phase(170, 29);
    run_phase(170, 87);
    run_phase(160, 0);

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d count, %0d touch, %0d remove and %0d clear items",
             op_tally[FN_COUNT], op_tally[FN_TOUCH], op_tally[FN_REMOVE], op_tally[FN_CLEAR]);
    $display("with a filled table, %0d-bit count saturation and three sender pacings",
             TALLY_W);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/kcls_pkg.sv
rtl/kcls_cell.sv
rtl/keyed_counter_least_select_top.sv
bench/kcls_table_checker.sv
bench/keyed_counter_least_select_top_test.sv
